/* design/lrrc_pkg.sv */
// ----------------------------------------------------------------------------
// lrrc_pkg
// Types, codes and the byte-wide CRC-32 update shared by the log record
// replay checker modules.
// ----------------------------------------------------------------------------
package lrrc_pkg;

    // Reflected CRC-32 polynomial and the all-ones initial and final value.
    localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [31:0] ALL_ONES = 32'hFFFF_FFFF;

    // Number of bytes in each header word.
    localparam int unsigned HEADER_BYTES = 4;

    // Reasons reported with the end-of-log summary.
    localparam logic [1:0] STOP_CLEAN         = 2'd0;
    localparam logic [1:0] STOP_TRUNC_HEADER  = 2'd1;
    localparam logic [1:0] STOP_TRUNC_PAYLOAD = 2'd2;
    localparam logic [1:0] STOP_CRC_MISMATCH  = 2'd3;

    // One input request.
    typedef struct packed {
        logic [7:0] log_byte;
        logic       end_of_log;
    } in_t;

    // One result request.
    typedef struct packed {
        logic [7:0]  payload_byte;
        logic        has_byte;
        logic        record_done;
        logic        record_good;
        logic        log_done;
        logic [1:0]  stop_reason;
        logic [31:0] good_records;
    } out_t;

    // Kinds of operation passed from the framing front to the checking back.
    typedef enum logic [1:0] {
        OP_PAYLOAD = 2'd0,
        OP_EMPTY   = 2'd1,
        OP_END     = 2'd2
    } op_kind_t;

    // One queued operation.
    typedef struct packed {
        op_kind_t    kind;
        logic [7:0]  data;
        logic        last;
        logic [31:0] check;
        logic [1:0]  reason;
    } op_t;

    // Fold one byte into the reflected CRC register.
    function automatic logic [31:0] crc_fold(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {24'd0, b};
        for (int k = 0; k < 8; k++) begin
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

endpackage

/* design/log_record_replay_checker.sv */
// ----------------------------------------------------------------------------
// log_record_replay_checker
// Deframes a byte stream of length/CRC-32 records, passes payload through and
// reports per-record checks and an end-of-log summary.
// ----------------------------------------------------------------------------
// Usage:
//   The s_ channel takes one log byte, or an end-of-log marker, per request.
//   The m_ channel returns at most one result per input request: a payload
//   byte (flagged as the end of a record, with its CRC verdict, on the last
//   byte), a record-done result for a zero-length record, or the summary
//   answering end-of-log. Header bytes and bytes after a CRC mismatch
//   produce no result.
//   The framing front writes the operation queue at the accepting edge, and
//   the CRC stage loads the result register when it pops the operation.
//   Throughput is one request per cycle while s_ready is high; the CRC
//   register update of one byte per cycle sets that rate.
//   When m_ready is low the result register holds and the queue fills;
//   s_ready drops only when the queue is full, and no request is lost.
//   Synchronous active-low reset empties the queue and result register and
//   returns framing, CRC, count and halt state to their start values; the
//   end-of-log summary does the same to that state.
// ----------------------------------------------------------------------------
module log_record_replay_checker #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  lrrc_pkg::in_t   s_data,
    output logic            m_valid,
    input  logic            m_ready,
    output lrrc_pkg::out_t  m_data
);

    logic           push;
    lrrc_pkg::op_t  push_op;
    logic           q_not_full;
    logic           pop;
    lrrc_pkg::op_t  pop_op;
    logic           q_not_empty;

    assign s_ready = q_not_full;

    // Framing front.
    lrrc_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_data     (s_data),
        .q_not_full (q_not_full),
        .push       (push),
        .push_op    (push_op)
    );

    // Operation queue.
    lrrc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_op   (push_op),
        .not_full  (q_not_full),
        .pop       (pop),
        .pop_op    (pop_op),
        .not_empty (q_not_empty)
    );

    // Checking back.
    lrrc_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .q_not_empty (q_not_empty),
        .q_op        (pop_op),
        .pop         (pop),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data)
    );

endmodule

/* design/lrrc_queue.sv */
// ----------------------------------------------------------------------------
// lrrc_queue
// Short register queue between the framing front and the checking back.
// ----------------------------------------------------------------------------
module lrrc_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push,
    input  lrrc_pkg::op_t   push_op,
    output logic            not_full,
    input  logic            pop,
    output lrrc_pkg::op_t   pop_op,
    output logic            not_empty
);

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] PTR_ONE  = PTR_W'(1);
    localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

    lrrc_pkg::op_t    store_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_full  = (count_reg != FULL_CNT);
    assign not_empty = (count_reg != '0);
    assign pop_op    = store_reg[rd_ptr_reg];

    // Pointer and fill-count update.
    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (push && !pop) begin
            count_next = count_reg + CNT_ONE;
        end else if (pop && !push) begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge aclk) begin
        if (push) begin
            store_reg[wr_ptr_reg] <= push_op;
        end
    end

endmodule

/* design/lrrc_front.sv */
// ----------------------------------------------------------------------------
// lrrc_front
// Framing front: assembles the length and check headers, counts payload
// bytes and queues an operation per payload byte, empty record or end-of-log.
// ----------------------------------------------------------------------------
module lrrc_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    input  lrrc_pkg::in_t   s_data,
    input  logic            q_not_full,
    output logic            push,
    output lrrc_pkg::op_t   push_op
);

    typedef enum logic [2:0] {
        ST_LEN = 3'b001,
        ST_CHK = 3'b010,
        ST_PAY = 3'b100
    } front_state_t;

    front_state_t state_reg, state_next;
    logic [1:0]   idx_reg, idx_next;
    logic [31:0]  length_reg, length_next;
    logic [31:0]  check_reg, check_next;
    logic [31:0]  remain_reg, remain_next;
    logic [31:0]  length_full;
    logic [31:0]  check_full;
    logic         accept;

    assign accept = s_valid && q_not_full;

    // Header words with the current byte placed at its lane.
    always_comb begin
        length_full = length_reg;
        check_full  = check_reg;
        unique case (idx_reg)
            2'd0: begin
                length_full[7:0]   = s_data.log_byte;
                check_full[7:0]    = s_data.log_byte;
            end
            2'd1: begin
                length_full[15:8]  = s_data.log_byte;
                check_full[15:8]   = s_data.log_byte;
            end
            2'd2: begin
                length_full[23:16] = s_data.log_byte;
                check_full[23:16]  = s_data.log_byte;
            end
            default: begin
                length_full[31:24] = s_data.log_byte;
                check_full[31:24]  = s_data.log_byte;
            end
        endcase
    end

    // Classify the request and advance the framing state.
    always_comb begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        length_next    = length_reg;
        check_next     = check_reg;
        remain_next    = remain_reg;
        push           = 1'b0;
        push_op.kind   = lrrc_pkg::OP_PAYLOAD;
        push_op.data   = s_data.log_byte;
        push_op.last   = (remain_reg == 32'd1);
        push_op.check  = check_reg;
        push_op.reason = lrrc_pkg::STOP_CLEAN;
        if (accept) begin
            if (s_data.end_of_log) begin
                push         = 1'b1;
                push_op.kind = lrrc_pkg::OP_END;
                if (state_reg == ST_PAY) begin
                    push_op.reason = lrrc_pkg::STOP_TRUNC_PAYLOAD;
                end else if (state_reg == ST_CHK || idx_reg != 2'd0) begin
                    push_op.reason = lrrc_pkg::STOP_TRUNC_HEADER;
                end
                state_next = ST_LEN;
                idx_next   = 2'd0;
            end else begin
                unique case (state_reg)
                    ST_LEN: begin
                        length_next = length_full;
                        idx_next    = idx_reg + 2'd1;
                        if (idx_reg == 2'(lrrc_pkg::HEADER_BYTES - 1)) begin
                            state_next = ST_CHK;
                        end
                    end
                    ST_CHK: begin
                        check_next = check_full;
                        idx_next   = idx_reg + 2'd1;
                        if (idx_reg == 2'(lrrc_pkg::HEADER_BYTES - 1)) begin
                            if (length_reg == 32'd0) begin
                                push          = 1'b1;
                                push_op.kind  = lrrc_pkg::OP_EMPTY;
                                push_op.check = check_full;
                                state_next    = ST_LEN;
                            end else begin
                                remain_next = length_reg;
                                state_next  = ST_PAY;
                            end
                        end
                    end
                    default: begin
                        push        = 1'b1;
                        remain_next = remain_reg - 32'd1;
                        if (remain_reg == 32'd1) begin
                            state_next = ST_LEN;
                        end
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LEN;
            idx_reg   <= 2'd0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    // Header and counter data: every byte is overwritten before use.
    always_ff @(posedge aclk) begin
        length_reg <= length_next;
        check_reg  <= check_next;
        remain_reg <= remain_next;
    end

endmodule

/* design/lrrc_back.sv */
// ----------------------------------------------------------------------------
// lrrc_back
// Checking back: runs the CRC over payload bytes, closes records, keeps the
// good-record count and halt state, and holds the result register.
// ----------------------------------------------------------------------------
module lrrc_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_not_empty,
    input  lrrc_pkg::op_t   q_op,
    output logic            pop,
    output logic            m_valid,
    input  logic            m_ready,
    output lrrc_pkg::out_t  m_data
);

    logic            out_valid_reg, out_valid_next;
    lrrc_pkg::out_t  out_reg, out_next;
    logic [31:0]     crc_reg, crc_next;
    logic [31:0]     count_reg, count_next;
    logic            halted_reg, halted_next;
    logic [31:0]     crc_fold;
    logic [31:0]     count_inc;
    logic            produce;
    logic            good;

    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;
    assign pop       = q_not_empty && (!out_valid_reg || m_ready);
    assign crc_fold  = lrrc_pkg::crc_fold(crc_reg, q_op.data);
    assign count_inc = (count_reg == lrrc_pkg::ALL_ONES) ? count_reg : count_reg + 32'd1;

    // Carry out one operation and build its result.
    always_comb begin
        crc_next    = crc_reg;
        count_next  = count_reg;
        halted_next = halted_reg;
        produce     = 1'b0;
        good        = 1'b0;
        out_next    = '0;
        if (pop) begin
            unique case (q_op.kind)
                lrrc_pkg::OP_END: begin
                    produce              = 1'b1;
                    out_next.log_done    = 1'b1;
                    out_next.stop_reason = halted_reg ? lrrc_pkg::STOP_CRC_MISMATCH
                                                      : q_op.reason;
                    out_next.good_records = count_reg;
                    crc_next    = lrrc_pkg::ALL_ONES;
                    count_next  = '0;
                    halted_next = 1'b0;
                end
                lrrc_pkg::OP_EMPTY: begin
                    if (!halted_reg) begin
                        produce = 1'b1;
                        good    = (q_op.check == 32'd0);
                        out_next.record_done = 1'b1;
                        out_next.record_good = good;
                    end
                end
                default: begin
                    if (!halted_reg) begin
                        produce = 1'b1;
                        out_next.payload_byte = q_op.data;
                        out_next.has_byte     = 1'b1;
                        crc_next              = crc_fold;
                        if (q_op.last) begin
                            good = ((crc_fold ^ lrrc_pkg::ALL_ONES) == q_op.check);
                            out_next.record_done = 1'b1;
                            out_next.record_good = good;
                            crc_next = lrrc_pkg::ALL_ONES;
                        end
                    end
                end
            endcase
            // A closed record either counts or halts replay.
            if (out_next.record_done) begin
                if (good) begin
                    count_next = count_inc;
                end else begin
                    halted_next = 1'b1;
                end
            end
            if (q_op.kind != lrrc_pkg::OP_END) begin
                out_next.good_records = count_next;
            end
        end
    end

    // Result register handshake.
    always_comb begin
        out_valid_next = out_valid_reg;
        if (m_ready) begin
            out_valid_next = 1'b0;
        end
        if (produce) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            crc_reg       <= lrrc_pkg::ALL_ONES;
            count_reg     <= '0;
            halted_reg    <= 1'b0;
        end else begin
            out_valid_reg <= out_valid_next;
            crc_reg       <= crc_next;
            count_reg     <= count_next;
            halted_reg    <= halted_next;
        end
    end

    // Result payload is loaded only when a new result is produced.
    always_ff @(posedge aclk) begin
        if (produce) begin
            out_reg <= out_next;
        end
    end

endmodule

/* verif/tb_log_record_replay_checker.sv */
// ----------------------------------------------------------------------------
// tb_log_record_replay_checker
// Self-checking bench for the log record replay checker. A short table of
// directed requests covers the empty log, an empty record with a good and a
// bad check, a maximal length cut short in its payload, a cut header and
// bytes ignored after a mismatch. Random logs of well-formed records with
// random content, bad checks, truncations and noise follow. Every accepted
// request is run through a local deframing and CRC-32 predictor, and each
// result is compared field by field with the oldest one predicted.
// ----------------------------------------------------------------------------
module tb_log_record_replay_checker;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned LONG_HOLD    = 300;
    localparam int unsigned DRAIN_CYCLES = 8;
    localparam int unsigned PHASE_ITEMS  = 570;

    // Where the predictor stands within the current record.
    typedef enum logic [1:0] {
        WANT_LENGTH,
        WANT_CHECK,
        IN_PAYLOAD,
        HALTED
    } replay_phase_t;

    // One stimulus request, with a hand-written result where it is obvious.
    typedef struct packed {
        lrrc_pkg::in_t  item;
        logic           typed;
        logic           yields;
        lrrc_pkg::out_t want;
    } stim_t;

    logic            aclk;
    logic            aresetn;
    logic            s_valid;
    logic            s_ready;
    lrrc_pkg::in_t   s_data;
    logic            m_valid;
    logic            m_ready;
    lrrc_pkg::out_t  m_data;

    // Predictor state.
    replay_phase_t rp_phase;
    logic [1:0]    hdr_pos;
    logic [31:0]   frame_length;
    logic [31:0]   frame_check;
    logic [31:0]   crc_acc;
    logic [31:0]   payload_left;
    logic [31:0]   good_count;
    logic [1:0]    halt_code;

    stim_t          log_stream[$];
    lrrc_pkg::out_t awaited_results[$];

    int unsigned send_idle_pct;
    int unsigned recv_idle_pct;
    bit          hold_request = 1'b0;
    int unsigned hold_left = 0;

    int unsigned    mismatch_count = 0;
    int unsigned    requests_sent = 0;
    int unsigned    results_checked = 0;
    int unsigned    records_good = 0;
    int unsigned    records_bad = 0;
    int unsigned    stop_tally[4] = '{0, 0, 0, 0};
    lrrc_pkg::out_t oldest_result;
    string          field_diffs;

    log_record_replay_checker dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // 12 ns clock.
    always begin
        aclk = 1'b0;
        #6;
        aclk = 1'b1;
        #6;
    end

    // Reflected CRC-32, one message bit at a time, least significant first.
    function automatic logic [31:0] crc32_byte(input logic [31:0] acc, input logic [7:0] b);
        logic [31:0] c;
        logic        fb;
        c = acc;
        for (int i = 0; i < 8; i++) begin
            fb = c[0] ^ b[i];
            c  = c >> 1;
            if (fb) begin
                c = c ^ lrrc_pkg::CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic void clear_replay();
        rp_phase     = WANT_LENGTH;
        hdr_pos      = 2'd0;
        frame_length = 32'd0;
        frame_check  = 32'd0;
        crc_acc      = lrrc_pkg::ALL_ONES;
        payload_left = 32'd0;
        good_count   = 32'd0;
        halt_code    = lrrc_pkg::STOP_CLEAN;
    endfunction

    // Settle the current record: count it if the check matches, else halt.
    function automatic logic close_record();
        logic good;
        good = ((crc_acc ^ lrrc_pkg::ALL_ONES) == frame_check);
        if (good) begin
            if (good_count != lrrc_pkg::ALL_ONES) begin
                good_count = good_count + 32'd1;
            end
            rp_phase     = WANT_LENGTH;
            frame_length = 32'd0;
            frame_check  = 32'd0;
        end else begin
            rp_phase  = HALTED;
            halt_code = lrrc_pkg::STOP_CRC_MISMATCH;
        end
        hdr_pos = 2'd0;
        return good;
    endfunction

    // Advance the predictor by one request; returns 1 when a result is due.
    function automatic logic predict_replay(input lrrc_pkg::in_t item,
                                            output lrrc_pkg::out_t res);
        logic good;
        res = '0;
        if (item.end_of_log) begin
            res.log_done     = 1'b1;
            res.good_records = good_count;
            if (rp_phase == HALTED) begin
                res.stop_reason = halt_code;
            end else if (rp_phase == IN_PAYLOAD) begin
                res.stop_reason = lrrc_pkg::STOP_TRUNC_PAYLOAD;
            end else if (rp_phase == WANT_CHECK || hdr_pos != 2'd0) begin
                res.stop_reason = lrrc_pkg::STOP_TRUNC_HEADER;
            end else begin
                res.stop_reason = lrrc_pkg::STOP_CLEAN;
            end
            clear_replay();
            return 1'b1;
        end
        case (rp_phase)
            WANT_LENGTH: begin
                frame_length = frame_length | ({24'd0, item.log_byte} << {hdr_pos, 3'b000});
                hdr_pos = hdr_pos + 2'd1;
                if (hdr_pos == 2'd0) begin
                    rp_phase = WANT_CHECK;
                end
                return 1'b0;
            end
            WANT_CHECK: begin
                frame_check = frame_check | ({24'd0, item.log_byte} << {hdr_pos, 3'b000});
                hdr_pos = hdr_pos + 2'd1;
                if (hdr_pos != 2'd0) begin
                    return 1'b0;
                end
                crc_acc      = lrrc_pkg::ALL_ONES;
                payload_left = frame_length;
                if (payload_left == 32'd0) begin
                    good             = close_record();
                    res.record_done  = 1'b1;
                    res.record_good  = good;
                    res.good_records = good_count;
                    return 1'b1;
                end
                rp_phase = IN_PAYLOAD;
                return 1'b0;
            end
            IN_PAYLOAD: begin
                crc_acc          = crc32_byte(crc_acc, item.log_byte);
                payload_left     = payload_left - 32'd1;
                res.payload_byte = item.log_byte;
                res.has_byte     = 1'b1;
                if (payload_left == 32'd0) begin
                    good            = close_record();
                    res.record_done = 1'b1;
                    res.record_good = good;
                end
                res.good_records = good_count;
                return 1'b1;
            end
            default: begin
                return 1'b0;
            end
        endcase
        return 1'b0;
    endfunction

    // Stimulus building.
    function automatic void queue_byte(input logic [7:0] b);
        stim_t s;
        s = '0;
        s.item.log_byte = b;
        log_stream.insert(log_stream.size(), s);
    endfunction

    function automatic void queue_end(input logic [7:0] b, input logic typed,
                                      input lrrc_pkg::out_t want);
        stim_t s;
        s = '0;
        s.item.log_byte   = b;
        s.item.end_of_log = 1'b1;
        s.typed           = typed;
        s.yields          = 1'b1;
        s.want            = want;
        log_stream.insert(log_stream.size(), s);
    endfunction

    function automatic void queue_word(input logic [31:0] w);
        for (int i = 0; i < 4; i++) begin
            queue_byte(w[8*i +: 8]);
        end
    endfunction

    function automatic lrrc_pkg::out_t summary_of(input logic [1:0] reason,
                                                  input logic [31:0] count);
        lrrc_pkg::out_t r;
        r              = '0;
        r.log_done     = 1'b1;
        r.stop_reason  = reason;
        r.good_records = count;
        return r;
    endfunction

    // Queue the first 'keep' bytes of a record with random payload; a corrupt
    // record carries a check with one bit flipped.
    function automatic void queue_record(input int unsigned len, input bit corrupt,
                                         input int unsigned keep);
        logic [7:0]  frame[$];
        logic [7:0]  pay[$];
        logic [31:0] crc;
        logic [31:0] chk;
        logic [31:0] len_word;
        logic [7:0]  b;
        crc      = lrrc_pkg::ALL_ONES;
        len_word = len;
        for (int i = 0; i < len; i++) begin
            b   = 8'($urandom_range(255));
            crc = crc32_byte(crc, b);
            pay.insert(pay.size(), b);
        end
        chk = crc ^ lrrc_pkg::ALL_ONES;
        if (corrupt) begin
            chk = chk ^ (32'h1 << $urandom_range(31));
        end
        for (int i = 0; i < 4; i++) begin
            frame.insert(frame.size(), len_word[8*i +: 8]);
        end
        for (int i = 0; i < 4; i++) begin
            frame.insert(frame.size(), chk[8*i +: 8]);
        end
        foreach (pay[i]) begin
            frame.insert(frame.size(), pay[i]);
        end
        for (int i = 0; i < keep && i < frame.size(); i++) begin
            queue_byte(frame[i]);
        end
    endfunction

    // Mostly short records, a few long ones.
    function automatic int unsigned pick_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 10) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 24);
        end else if (r < 98) begin
            return $urandom_range(25, 80);
        end
        return $urandom_range(81, 260);
    endfunction

    // Directed table: typed results only for the summaries.
    function automatic void build_directed();
        queue_end(8'hFF, 1'b1, summary_of(lrrc_pkg::STOP_CLEAN, 32'd0));
        // Empty record whose stored check is the empty CRC.
        queue_word(32'd0);
        queue_word(32'd0);
        // Largest length, cut short in its payload.
        queue_word(32'hFFFF_FFFF);
        queue_word(32'd0);
        queue_byte(8'hFF);
        queue_end(8'h00, 1'b1, summary_of(lrrc_pkg::STOP_TRUNC_PAYLOAD, 32'd1));
        // Cut within the length header.
        queue_byte(8'h12);
        queue_end(8'h5A, 1'b1, summary_of(lrrc_pkg::STOP_TRUNC_HEADER, 32'd0));
        // Empty record with a wrong check, then a byte that must be ignored.
        queue_word(32'd0);
        queue_word(32'h0000_00FF);
        queue_byte(8'hAB);
        queue_end(8'hA5, 1'b1, summary_of(lrrc_pkg::STOP_CRC_MISMATCH, 32'd0));
    endfunction

    // Random logs until about 'target' requests that the block acts upon.
    function automatic void build_random_logs(input int unsigned target);
        int unsigned made;
        int unsigned nrec;
        int unsigned len;
        int unsigned r;
        int unsigned k;
        bit          halted;
        made = 0;
        while (made < target) begin
            nrec   = $urandom_range(1, 6);
            halted = 1'b0;
            r      = $urandom_range(99);
            for (int n = 0; n < nrec && !halted; n++) begin
                len    = pick_length();
                halted = ($urandom_range(99) < 8);
                queue_record(len, halted, len + 8);
                made += len + 8;
            end
            if (halted) begin
                // Trailing bytes after a bad check are ignored.
                k = $urandom_range(1, 6);
                repeat (k) queue_byte(8'($urandom_range(255)));
            end else if (r < 10) begin
                k = $urandom_range(1, 7);
                queue_record(pick_length(), 1'b0, k);
                made += k;
            end else if (r < 20) begin
                len = $urandom_range(2, 40);
                k   = $urandom_range(9, len + 7);
                queue_record(len, 1'b0, k);
                made += k;
            end else if (r < 28) begin
                k = $urandom_range(1, 12);
                repeat (k) queue_byte(8'($urandom_range(255)));
                made += k;
            end
            queue_end(8'($urandom_range(255)), 1'b0, '0);
            made++;
        end
    endfunction

    // Offer one request, entered and left at a falling edge.
    task automatic offer(input stim_t st);
        lrrc_pkg::out_t res;
        logic           yields;
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= st.item;
        @(posedge aclk);
        while (!s_ready) begin
            @(posedge aclk);
        end
        yields = predict_replay(st.item, res);
        if (st.typed) begin
            yields = st.yields;
            res    = st.want;
        end
        if (yields) begin
            awaited_results.insert(awaited_results.size(), res);
        end
        requests_sent++;
        @(negedge aclk);
    endtask

    task automatic drive_stream();
        stim_t st;
        while (log_stream.size() != 0) begin
            st = log_stream.pop_front();
            offer(st);
        end
    endtask

    function automatic string fmt_result(input lrrc_pkg::out_t r);
        return $sformatf("byte=%h has=%b done=%b good=%b log=%b reason=%0d count=%0d",
                         r.payload_byte, r.has_byte, r.record_done, r.record_good,
                         r.log_done, r.stop_reason, r.good_records);
    endfunction

    function automatic void note_failure(input string msg);
        mismatch_count++;
        if (mismatch_count <= 10) begin
            $display("mismatch at %0t: %s", $realtime, msg);
        end
    endfunction

    // Result side: random back-pressure, with one long hold when requested.
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_request) begin
                hold_request = 1'b0;
                hold_left    = LONG_HOLD;
            end
            if (hold_left != 0) begin
                m_ready <= 1'b0;
                hold_left--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    // Compare each accepted result with the oldest one predicted.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            results_checked++;
            if (awaited_results.size() == 0) begin
                note_failure({"result with none predicted: ", fmt_result(m_data)});
            end else begin
                oldest_result = awaited_results.pop_front();
                field_diffs   = "";
                if (m_data.payload_byte !== oldest_result.payload_byte)
                    field_diffs = {field_diffs, " payload_byte"};
                if (m_data.has_byte !== oldest_result.has_byte)
                    field_diffs = {field_diffs, " has_byte"};
                if (m_data.record_done !== oldest_result.record_done)
                    field_diffs = {field_diffs, " record_done"};
                if (m_data.record_good !== oldest_result.record_good)
                    field_diffs = {field_diffs, " record_good"};
                if (m_data.log_done !== oldest_result.log_done)
                    field_diffs = {field_diffs, " log_done"};
                if (m_data.stop_reason !== oldest_result.stop_reason)
                    field_diffs = {field_diffs, " stop_reason"};
                if (m_data.good_records !== oldest_result.good_records)
                    field_diffs = {field_diffs, " good_records"};
                if (field_diffs != "") begin
                    note_failure({"fields", field_diffs, " differ; expected ",
                                  fmt_result(oldest_result), ", got ", fmt_result(m_data)});
                end
            end
            if (m_data.record_done === 1'b1) begin
                if (m_data.record_good === 1'b1) begin
                    records_good++;
                end else begin
                    records_bad++;
                end
            end
            if (m_data.log_done === 1'b1) begin
                stop_tally[m_data.stop_reason]++;
            end
        end
    end

    // Main sequence.
    initial begin
        clear_replay();
        aresetn       = 1'b0;
        s_valid       = 1'b0;
        s_data        = '0;
        send_idle_pct = 18;
        recv_idle_pct = 63;
        repeat (9) @(negedge aclk);
        aresetn <= 1'b1;

        build_directed();
        drive_stream();

        // Busy sender, sparse receiver.
        build_random_logs(PHASE_ITEMS);
        drive_stream();

        // Sparse sender, busy receiver.
        send_idle_pct = 63;
        recv_idle_pct = 18;
        build_random_logs(PHASE_ITEMS);
        drive_stream();

        // Full rate both ways, opening with a long output hold.
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_request  = 1'b1;
        build_random_logs(PHASE_ITEMS);
        drive_stream();
        s_valid <= 1'b0;

        while (awaited_results.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);

        $display("Sent %0d requests and checked %0d results; %0d records passed, %0d failed.",
                 requests_sent, results_checked, records_good, records_bad);
        $display("Logs closed: clean %0d, cut header %0d, cut payload %0d, bad check %0d.",
                 stop_tally[0], stop_tally[1], stop_tally[2], stop_tally[3]);
        if (mismatch_count == 0) begin
            $display("[log_record_replay_checker] OK");
        end else begin
            $display("[log_record_replay_checker] ERROR");
        end
        $finish;
    end

    // Watchdog.
    initial begin
        #2_000_000;
        $display("[log_record_replay_checker] ERROR");
        $finish;
    end

endmodule

/* filelist.f */
design/lrrc_pkg.sv
design/lrrc_queue.sv
design/lrrc_front.sv
design/lrrc_back.sv
design/log_record_replay_checker.sv
verif/tb_log_record_replay_checker.sv
